// File: src/iia_pkg.sv
// Shared types and constants for the iterative intercept aim point block.
package iia_pkg;

	localparam int IIA_MAX_ITER = 5;
	localparam logic [23:0] SPEED_RESET = 24'd20480;

	localparam int ROOT_W = 33;
	localparam int T_W = 49;
	localparam int ACC_W = 66;
	localparam int PROD_W = 83;
	localparam int SQRT_STEPS = 33;
	localparam int DIV_STEPS = 49;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ_LO,
		OP_SQ_HI,
		OP_ACC,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_VEL_LO,
		OP_VEL_HI,
		OP_MOVE,
		OP_TRV_LO,
		OP_TRV_HI,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
		logic [1:0] comp;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		logic miss_gt;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		logic signed [31:0] aim_x;
		logic signed [31:0] aim_y;
		logic signed [31:0] aim_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [30:0] hit_radius;
		logic signed [31:0] shooter_x;
		logic signed [31:0] shooter_y;
		logic signed [31:0] shooter_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] lead_x;
		logic signed [31:0] lead_y;
		logic signed [31:0] lead_z;
	} out_word_t;

endpackage

// File: src/iia_if.sv
// Channel interfaces: request, result and speed configuration.
interface iia_req_if;
	logic valid;
	logic ready;
	logic signed [31:0] aim_x;
	logic signed [31:0] aim_y;
	logic signed [31:0] aim_z;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic [30:0] hit_radius;
	logic signed [31:0] shooter_x;
	logic signed [31:0] shooter_y;
	logic signed [31:0] shooter_z;
	modport source (output valid, aim_x, aim_y, aim_z, vel_x, vel_y, vel_z, hit_radius,
		shooter_x, shooter_y, shooter_z, input ready);
	modport sink (input valid, aim_x, aim_y, aim_z, vel_x, vel_y, vel_z, hit_radius,
		shooter_x, shooter_y, shooter_z, output ready);
endinterface

interface iia_rsp_if;
	logic valid;
	logic ready;
	logic signed [31:0] lead_x;
	logic signed [31:0] lead_y;
	logic signed [31:0] lead_z;
	modport source (output valid, lead_x, lead_y, lead_z, input ready);
	modport sink (input valid, lead_x, lead_y, lead_z, output ready);
endinterface

interface iia_cfg_if;
	logic valid;
	logic ready;
	logic [23:0] shot_speed;
	modport source (output valid, shot_speed, input ready);
	modport sink (input valid, shot_speed, output ready);
endinterface

// File: src/iia_ctrl.sv
// Sequencer for intercept passes: at most one datapath command per cycle.
module iia_ctrl import iia_pkg::*; #(
	parameter int MAX_ITERATIONS = IIA_MAX_ITER
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output cmd_t  cmd
);
	localparam int IW = $clog2(MAX_ITERATIONS + 1);

	typedef enum logic [14:0] {
		S_IDLE      = 15'h0001,
		S_SQ_LO     = 15'h0002,
		S_SQ_HI     = 15'h0004,
		S_SQ_ACC    = 15'h0008,
		S_SQRT_INIT = 15'h0010,
		S_SQRT      = 15'h0020,
		S_DIV_INIT  = 15'h0040,
		S_DIV       = 15'h0080,
		S_VEL_LO    = 15'h0100,
		S_VEL_HI    = 15'h0200,
		S_MOVE      = 15'h0400,
		S_TRV_LO    = 15'h0800,
		S_TRV_HI    = 15'h1000,
		S_MISS      = 15'h2000,
		S_FIN       = 15'h4000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] comp_q, comp_d;
	logic [5:0] cnt_q, cnt_d;
	logic [IW-1:0] iter_q, iter_d;
	logic phase_q, phase_d;
	logic [IW-1:0] iter_nx;

	assign iter_nx = iter_q + IW'(1);

	always_comb begin
		state_d = state_q;
		comp_d = comp_q;
		cnt_d = cnt_q;
		iter_d = iter_q;
		phase_d = phase_q;
		cmd.op = OP_NONE;
		cmd.comp = comp_q;
		cmd.in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					comp_d = 2'd0;
					phase_d = 1'b0;
					iter_d = '0;
					state_d = S_SQ_LO;
				end
			end
			S_SQ_LO: begin
				cmd.op = OP_SQ_LO;
				state_d = S_SQ_HI;
			end
			S_SQ_HI: begin
				cmd.op = OP_SQ_HI;
				state_d = S_SQ_ACC;
			end
			S_SQ_ACC: begin
				cmd.op = OP_ACC;
				if (comp_q == 2'd2) begin
					comp_d = 2'd0;
					state_d = S_SQRT_INIT;
				end else begin
					comp_d = comp_q + 2'd1;
					state_d = S_SQ_LO;
				end
			end
			S_SQRT_INIT: begin
				cmd.op = OP_SQRT_INIT;
				cnt_d = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(SQRT_STEPS - 1))
					state_d = phase_q ? S_TRV_LO : S_DIV_INIT;
			end
			S_DIV_INIT: begin
				cmd.op = OP_DIV_INIT;
				cnt_d = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					comp_d = 2'd0;
					state_d = S_VEL_LO;
				end
			end
			S_VEL_LO: begin
				cmd.op = OP_VEL_LO;
				state_d = S_VEL_HI;
			end
			S_VEL_HI: begin
				cmd.op = OP_VEL_HI;
				state_d = S_MOVE;
			end
			S_MOVE: begin
				cmd.op = OP_MOVE;
				if (comp_q == 2'd2) begin
					comp_d = 2'd0;
					phase_d = 1'b1;
					state_d = S_SQ_LO;
				end else begin
					comp_d = comp_q + 2'd1;
					state_d = S_VEL_LO;
				end
			end
			S_TRV_LO: begin
				cmd.op = OP_TRV_LO;
				state_d = S_TRV_HI;
			end
			S_TRV_HI: begin
				cmd.op = OP_TRV_HI;
				state_d = S_MISS;
			end
			S_MISS: begin
				iter_d = iter_nx;
				// another pass only while the miss is too large and passes remain
				if (stat.miss_gt && (int'(iter_nx) < MAX_ITERATIONS)) begin
					phase_d = 1'b0;
					comp_d = 2'd0;
					state_d = S_SQ_LO;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd.op = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			comp_q <= '0;
			cnt_q <= '0;
			iter_q <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			comp_q <= comp_d;
			cnt_q <= cnt_d;
			iter_q <= iter_d;
			phase_q <= phase_d;
		end
	end

endmodule

// File: src/iia_dpath.sv
// Datapath: operand registers, split multiplier, bit-serial square root and divider.
module iia_dpath import iia_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output stat_t     stat,
	input  in_word_t  in_word,
	input  logic      cfg_valid,
	input  logic [23:0] cfg_speed,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);
	logic signed [31:0] aim_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] sh_q [3];
	logic signed [31:0] pt_q [3];
	logic signed [31:0] lead_q [3];
	logic [30:0] radius_q;
	logic [23:0] speed_q;
	logic out_valid_q;

	logic [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] rad_q;
	logic [35:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [T_W-1:0] quo_q;
	logic [23:0] drem_q;

	logic [23:0] speed;
	logic signed [32:0] diff;
	logic [32:0] dmag, vmag;
	logic [49:0] op_a;
	logic [32:0] op_b;
	logic [57:0] p_lo, p_hi;
	logic [35:0] rem_sh, trial;
	logic sq_ge;
	logic [24:0] dr;
	logic dv_ge;
	logic [66:0] mag_full;
	logic [40:0] mag41;
	logic signed [42:0] mv, sum;
	logic signed [31:0] moved;
	logic [56:0] travel;
	logic [57:0] miss;

	assign speed = (speed_q == 24'd0) ? 24'd1 : speed_q;

	assign diff = {pt_q[cmd.comp][31], pt_q[cmd.comp]} - {sh_q[cmd.comp][31], sh_q[cmd.comp]};
	assign dmag = diff[32] ? 33'(-diff) : 33'(diff);
	assign vmag = vel_q[cmd.comp][31] ? 33'(-{vel_q[cmd.comp][31], vel_q[cmd.comp]})
		: 33'({1'b0, vel_q[cmd.comp]});

	always_comb begin
		case (cmd.op)
			OP_SQ_LO, OP_SQ_HI: begin
				op_a = 50'(dmag);
				op_b = dmag;
			end
			OP_VEL_LO, OP_VEL_HI: begin
				op_a = 50'(quo_q);
				op_b = vmag;
			end
			OP_TRV_LO, OP_TRV_HI: begin
				op_a = 50'(quo_q);
				op_b = 33'(speed);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign p_lo = 58'(op_a[24:0]) * 58'(op_b);
	assign p_hi = 58'(op_a[49:25]) * 58'(op_b);

	// one root bit per step
	assign rem_sh = {rem_q[33:0], rad_q[ACC_W-1:ACC_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign sq_ge = rem_sh >= trial;

	// one quotient bit per step
	assign dr = {drem_q, quo_q[T_W-1]};
	assign dv_ge = dr >= {1'b0, speed};

	// target motion, clamped to 2^40, then added to the aim point and saturated
	assign mag_full = prod_q[PROD_W-1:16];
	assign mag41 = (mag_full > (67'd1 << 40)) ? (41'd1 << 40) : mag_full[40:0];
	assign mv = vel_q[cmd.comp][31] ? -$signed({2'b00, mag41}) : $signed({2'b00, mag41});
	assign sum = 43'(aim_q[cmd.comp]) + mv;
	always_comb begin
		if (sum > 43'sd2147483647)
			moved = 32'sh7fffffff;
		else if (sum < -43'sd2147483648)
			moved = 32'sh80000000;
		else
			moved = sum[31:0];
	end

	assign travel = prod_q[72:16];
	assign miss = (58'(root_q) >= 58'(travel)) ? 58'(root_q) - 58'(travel)
		: 58'(travel) - 58'(root_q);
	assign stat.miss_gt = (root_q != '0) && (miss > 58'(radius_q));
	assign stat.out_busy = out_valid_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				aim_q[0] <= in_word.aim_x;
				aim_q[1] <= in_word.aim_y;
				aim_q[2] <= in_word.aim_z;
				pt_q[0] <= in_word.aim_x;
				pt_q[1] <= in_word.aim_y;
				pt_q[2] <= in_word.aim_z;
				vel_q[0] <= in_word.vel_x;
				vel_q[1] <= in_word.vel_y;
				vel_q[2] <= in_word.vel_z;
				sh_q[0] <= in_word.shooter_x;
				sh_q[1] <= in_word.shooter_y;
				sh_q[2] <= in_word.shooter_z;
				radius_q <= in_word.hit_radius;
				acc_q <= '0;
			end
			OP_SQ_LO, OP_VEL_LO, OP_TRV_LO: prod_q <= PROD_W'(p_lo);
			OP_SQ_HI, OP_VEL_HI, OP_TRV_HI: prod_q <= prod_q + {p_hi, 25'd0};
			OP_ACC: acc_q <= acc_q + prod_q[ACC_W-1:0];
			OP_SQRT_INIT: begin
				rad_q <= acc_q;
				acc_q <= '0;
				rem_q <= '0;
				root_q <= '0;
			end
			OP_SQRT_STEP: begin
				rem_q <= sq_ge ? rem_sh - trial : rem_sh;
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
				rad_q <= {rad_q[ACC_W-3:0], 2'b00};
			end
			OP_DIV_INIT: begin
				quo_q <= {root_q, 16'd0};
				drem_q <= '0;
			end
			OP_DIV_STEP: begin
				drem_q <= dv_ge ? 24'(dr - {1'b0, speed}) : dr[23:0];
				quo_q <= {quo_q[T_W-2:0], dv_ge};
			end
			OP_MOVE: pt_q[cmd.comp] <= moved;
			OP_OUT: begin
				lead_q[0] <= pt_q[0];
				lead_q[1] <= pt_q[1];
				lead_q[2] <= pt_q[2];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				speed_q <= cfg_speed;
			if (cmd.op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word.lead_x = lead_q[0];
	assign out_word.lead_y = lead_q[1];
	assign out_word.lead_z = lead_q[2];

endmodule

// File: src/iterative_intercept_aim_point_top.sv
// Iterative projectile intercept: predicts where to aim a projectile of set speed.
//
// Channels: req takes one word (aim point, target velocity and shooter position,
// signed Q23.8, and hit radius, unsigned Q23.8); rsp returns one word with the lead
// point; cfg writes the projectile speed (always ready, write only while idle).
// Each pass squares and sums three differences, takes a bit-serial square root,
// divides distance by speed one quotient bit a cycle, moves the point, repeats
// the distance and finishes with the travel product and miss test. One word is
// in work at a time.
// The result sits in an output register; the next request is taken while it
// waits, and a finished word holds in the sequencer until the register frees.
// Reset clears the sequencer and the result valid and sets speed to 80.0.
module iterative_intercept_aim_point_top import iia_pkg::*; #(
	parameter int MAX_ITERATIONS = IIA_MAX_ITER
) (
	input logic clk,
	input logic arst_n,
	iia_req_if.sink req,
	iia_rsp_if.source rsp,
	iia_cfg_if.sink cfg
);
	cmd_t cmd;
	stat_t stat;
	in_word_t in_word;
	out_word_t out_word;

	assign in_word = '{aim_x: req.aim_x, aim_y: req.aim_y, aim_z: req.aim_z,
		vel_x: req.vel_x, vel_y: req.vel_y, vel_z: req.vel_z,
		hit_radius: req.hit_radius, shooter_x: req.shooter_x,
		shooter_y: req.shooter_y, shooter_z: req.shooter_z};

	assign req.ready = cmd.in_ready;
	assign cfg.ready = 1'b1;
	assign rsp.lead_x = out_word.lead_x;
	assign rsp.lead_y = out_word.lead_y;
	assign rsp.lead_z = out_word.lead_z;

	iia_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.stat(stat),
		.cmd(cmd)
	);

	iia_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.in_word(in_word),
		.cfg_valid(cfg.valid),
		.cfg_speed(cfg.shot_speed),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_word(out_word)
	);

endmodule

// File: src/iia_chk.sv
// Port checker for the intercept block, bound to the top level.
module iia_chk (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [31:0] lead_x,
	input logic [31:0] lead_y,
	input logic [31:0] lead_z
);
	// one word in work: no request taken right after another
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken back to back");

	a_no_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_valid && req_ready))
		else $error("result right after request");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(lead_x) && $stable(lead_y) && $stable(lead_z))
		else $error("result changed while stalled");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("speed write refused");

endmodule

bind iterative_intercept_aim_point_top iia_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready),
	.lead_x(rsp.lead_x),
	.lead_y(rsp.lead_y),
	.lead_z(rsp.lead_z)
);

// File: tb/sv/tb_iterative_intercept_aim_point_top.sv
// Testbench for the intercept lead block: directed and random requests checked against a local predictor.
module tb_iterative_intercept_aim_point_top;
	timeunit 1ns;
	timeprecision 1ps;
	import iia_pkg::*;

	class lead_scoreboard;
		logic [23:0] speed;
		out_word_t leads_due[$];
		int errors;

		function new();
			speed = SPEED_RESET;
			errors = 0;
		endfunction

		// floor of the square root of the summed squared components
		function logic [127:0] vec_len(longint dx, longint dy, longint dz);
			logic [127:0] sum, c, r;
			logic [127:0] m;
			longint comp [3];
			sum = 0;
			r = 0;
			comp[0] = dx;
			comp[1] = dy;
			comp[2] = dz;
			for (int i = 0; i < 3; i++) begin
				m = (comp[i] < 0) ? 128'(-comp[i]) : 128'(comp[i]);
				sum += m * m;
			end
			for (int b = 35; b >= 0; b--) begin
				c = r | (128'd1 << b);
				if (c * c <= sum)
					r = c;
			end
			return r;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		function out_word_t predict_lead(in_word_t w);
			longint aim [3], vel [3], shp [3], pt [3];
			logic [127:0] dist0, dist1, flight, travel, prod, mag, miss, spd;
			longint mv;
			int passes;
			out_word_t o;
			spd = (speed == 0) ? 128'd1 : 128'(speed);
			aim[0] = w.aim_x;
			aim[1] = w.aim_y;
			aim[2] = w.aim_z;
			vel[0] = w.vel_x;
			vel[1] = w.vel_y;
			vel[2] = w.vel_z;
			shp[0] = w.shooter_x;
			shp[1] = w.shooter_y;
			shp[2] = w.shooter_z;
			for (int i = 0; i < 3; i++)
				pt[i] = aim[i];
			passes = 0;
			do begin
				dist0 = vec_len(pt[0] - shp[0], pt[1] - shp[1], pt[2] - shp[2]);
				flight = (dist0 << 16) / spd;
				for (int i = 0; i < 3; i++) begin
					prod = ((vel[i] < 0) ? 128'(-vel[i]) : 128'(vel[i])) * flight;
					mag = prod >> 16;
					if (mag > (128'd1 << 40))
						mag = 128'd1 << 40;
					mv = (vel[i] < 0) ? -longint'(mag) : longint'(mag);
					pt[i] = clamp32(aim[i] + mv);
				end
				dist1 = vec_len(pt[0] - shp[0], pt[1] - shp[1], pt[2] - shp[2]);
				travel = (spd * flight) >> 16;
				if (dist1 == 0)
					miss = 0;
				else
					miss = (dist1 > travel) ? dist1 - travel : travel - dist1;
				passes++;
			end while (miss > 128'(w.hit_radius) && passes < IIA_MAX_ITER);
			o.lead_x = pt[0][31:0];
			o.lead_y = pt[1][31:0];
			o.lead_z = pt[2][31:0];
			return o;
		endfunction

		function void note_request(in_word_t w);
			leads_due.push_back(predict_lead(w));
		endfunction

		function void check_lead(out_word_t got);
			out_word_t want;
			if (leads_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected lead word %h %h %h", got.lead_x, got.lead_y,
						got.lead_z);
				return;
			end
			want = leads_due.pop_front();
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("lead differs: expected %h %h %h, got %h %h %h",
						want.lead_x, want.lead_y, want.lead_z,
						got.lead_x, got.lead_y, got.lead_z);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int hold_left;

	iia_req_if req ();
	iia_rsp_if rsp ();
	iia_cfg_if cfg ();

	iterative_intercept_aim_point_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	lead_scoreboard lead_sb = new();

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#200ms;
		$display("iterative_intercept_aim_point_top: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		out_word_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.lead_x = rsp.lead_x;
			got.lead_y = rsp.lead_y;
			got.lead_z = rsp.lead_z;
			lead_sb.check_lead(got);
		end
	end

	// result side: random stalls, some long, plus forced hold-offs
	initial begin
		int stall_left;
		stall_left = 0;
		hold_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp.ready = 1'b0;
				stall_left--;
			end else begin
				if ($urandom_range(0, 299) == 0)
					stall_left = $urandom_range(100, 2000);
				rsp.ready = ($urandom_range(0, 9) < 6);
			end
		end
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 400);
	endfunction

	function logic [31:0] rand_coord(int spread);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'hffff_ffff;
					3: return 32'd1;
					default: return 32'd0;
				endcase
			end
			default: return 32'($signed($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	function in_word_t rand_request();
		in_word_t w;
		int spread;
		spread = (1 << $urandom_range(8, 26));
		w.aim_x = rand_coord(spread);
		w.aim_y = rand_coord(spread);
		w.aim_z = rand_coord(spread);
		w.vel_x = rand_coord(spread >> 2);
		w.vel_y = rand_coord(spread >> 2);
		w.vel_z = rand_coord(spread >> 2);
		w.shooter_x = rand_coord(spread);
		w.shooter_y = rand_coord(spread);
		w.shooter_z = rand_coord(spread);
		case ($urandom_range(0, 5))
			0: w.hit_radius = 31'd0;
			1: w.hit_radius = 31'($urandom());
			2: w.hit_radius = 31'h7fff_ffff;
			default: w.hit_radius = 31'($urandom_range(0, 4096));
		endcase
		// shooter sitting on the aim point
		if ($urandom_range(0, 29) == 0) begin
			w.shooter_x = w.aim_x;
			w.shooter_y = w.aim_y;
			w.shooter_z = w.aim_z;
		end
		return w;
	endfunction

	function in_word_t make_request(logic [31:0] a, logic [31:0] v, logic [30:0] rad,
		logic [31:0] s);
		in_word_t w;
		w.aim_x = a;
		w.aim_y = -a;
		w.aim_z = a ^ 32'h0000_ff00;
		w.vel_x = v;
		w.vel_y = ~v;
		w.vel_z = -v;
		w.hit_radius = rad;
		w.shooter_x = s;
		w.shooter_y = s;
		w.shooter_z = -s;
		return w;
	endfunction

	// call at a falling edge; returns at a falling edge
	task automatic send_request(in_word_t w, int gap);
		req.valid = 1'b1;
		req.aim_x = w.aim_x;
		req.aim_y = w.aim_y;
		req.aim_z = w.aim_z;
		req.vel_x = w.vel_x;
		req.vel_y = w.vel_y;
		req.vel_z = w.vel_z;
		req.hit_radius = w.hit_radius;
		req.shooter_x = w.shooter_x;
		req.shooter_y = w.shooter_y;
		req.shooter_z = w.shooter_z;
		do
			@(posedge clk);
		while (!req.ready);
		lead_sb.note_request(w);
		@(negedge clk);
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		// drop valid first so the last word is not taken again
		req.valid = 1'b0;
		while (lead_sb.leads_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_speed(logic [23:0] v);
		cfg.valid = 1'b1;
		cfg.shot_speed = v;
		do
			@(posedge clk);
		while (!cfg.ready);
		lead_sb.speed = v;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	initial begin
		logic [23:0] speeds [8];
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.aim_x = '0;
		req.aim_y = '0;
		req.aim_z = '0;
		req.vel_x = '0;
		req.vel_y = '0;
		req.vel_z = '0;
		req.hit_radius = '0;
		req.shooter_x = '0;
		req.shooter_y = '0;
		req.shooter_z = '0;
		cfg.valid = 1'b0;
		cfg.shot_speed = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words at the reset speed
		send_request(make_request(32'd0, 32'd0, 31'd0, 32'd0), 0);
		send_request(make_request(32'h7fff_ffff, 32'h7fff_ffff, 31'd0, 32'h8000_0000), 0);
		send_request(make_request(32'h8000_0000, 32'h8000_0000, 31'd0, 32'h7fff_ffff), 1);
		send_request(make_request(32'h0001_0000, 32'h0000_0a00, 31'd0, 32'd0), 0);
		send_request(make_request(32'h0001_0000, 32'h0000_0a00, 31'h7fff_ffff, 32'd0), 2);
		send_request(make_request(32'h0001_0000, 32'h0000_0a00, 31'd256, 32'd0), 0);
		send_request(make_request(32'h1234_5678, 32'd0, 31'd0, 32'h1234_5678), 0);
		send_request(make_request(32'hffff_ffff, 32'hffff_ffff, 31'd1, 32'd1), 3);
		send_request(make_request(32'h0010_0000, 32'h7fff_0000, 31'd0, 32'hfff0_0000), 0);
		send_request(make_request(32'h8000_0000, 32'h7fff_ffff, 31'h5555_5555, 32'h7fff_ffff), 0);
		send_request(make_request(32'h0000_5000, 32'h0000_5000, 31'd0, 32'd0), 0);
		send_request(make_request(32'haaaa_aaaa, 32'h5555_5555, 31'h2aaa_aaaa, 32'h5555_5555), 0);
		drain();

		// speed extremes, zero treated as one, the reset speed, then random speeds
		speeds[0] = 24'd1;
		speeds[1] = 24'hff_ffff;
		speeds[2] = 24'd0;
		speeds[3] = SPEED_RESET;
		speeds[4] = 24'($urandom_range(1, 24'hff_ffff));
		speeds[5] = 24'($urandom_range(256, 65536));
		speeds[6] = 24'($urandom_range(1, 255));
		speeds[7] = 24'($urandom_range(4096, 200000));
		foreach (speeds[p]) begin
			write_speed(speeds[p]);
			for (int n = 0; n < 145; n++) begin
				// long hold-off on the result side while requests keep coming
				if (p == 3 && n == 10)
					hold_left = 3000;
				// let everything drain mid-phase once
				if (p == 5 && n == 70)
					drain();
				send_request(rand_request(), (p == 3 && n < 40) ? 0 : pick_gap());
			end
			drain();
		end

		repeat (100) @(negedge clk);
		if (lead_sb.errors == 0 && lead_sb.leads_due.size() == 0)
			$display("iterative_intercept_aim_point_top: match");
		else
			$display("iterative_intercept_aim_point_top: mismatch");
		$finish;
	end
endmodule

// File: sim.f
src/iia_pkg.sv
src/iia_if.sv
src/iia_ctrl.sv
src/iia_dpath.sv
src/iterative_intercept_aim_point_top.sv
src/iia_chk.sv
tb/sv/tb_iterative_intercept_aim_point_top.sv
